>>> src/hashed_port_pool_allocator_assert.svh
// ---------------------------------------------------------------------------
// hashed port pool allocator assertion macros
// clocked assertion helpers used by the allocator back end
// ---------------------------------------------------------------------------
`ifndef HASHED_PORT_POOL_ALLOCATOR_ASSERT_SVH
`define HASHED_PORT_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define HPA_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define HPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/hpa_pkg.sv
// ---------------------------------------------------------------------------
// hpa_pkg
// shared types, codes and helpers of the hashed port pool allocator
// ---------------------------------------------------------------------------
`default_nettype none

package hpa_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_INIT    = 2'd0,
      REQ_FETCH   = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_NOT_USED   = 3'd2,
      ST_BAD_CONFIG = 3'd3,
      ST_BAD_PORT   = 3'd4
   } status_type;

   // register indexes
   localparam logic [2:0] CSR_PORT_LOW    = 3'd0;
   localparam logic [2:0] CSR_PORT_HIGH   = 3'd1;
   localparam logic [2:0] CSR_INDEX_SHIFT = 3'd2;
   localparam logic [2:0] CSR_PORT_BASE   = 3'd3;
   localparam logic [2:0] CSR_POOL_COUNT  = 3'd4;

   // port range used when a bound register holds zero
   localparam logic [15:0] DEFAULT_LOW  = 16'd1025;
   localparam logic [15:0] DEFAULT_HIGH = 16'hffff;

   // widest pool index carried between front and back
   localparam int POOL_MAX_W = 7;

   typedef struct packed {
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic [3:0]  index_shift;
      logic [14:0] port_base;
      logic [4:0]  pool_count;
   } cfg_type;

   // classified request word passed from front to back
   typedef struct packed {
      req_kind_type          kind;
      logic [POOL_MAX_W-1:0] pool;
      logic [15:0]           rport;
   } item_type;

   // number of pools in use: zero counts as one, capped at the pool limit
   function automatic logic [7:0] active_pools(input logic [4:0] cnt,
                                               input logic [7:0] limit);
      if (cnt == 5'd0) return 8'd1;
      if ({3'b000, cnt} > limit) return limit;
      return {3'b000, cnt};
   endfunction

endpackage

`default_nettype wire

>>> src/hpa_front.sv
// ---------------------------------------------------------------------------
// hpa_front
// accepts request words and picks the pool with an iterative modulo unit
// ---------------------------------------------------------------------------
`default_nettype none

module hpa_front
   import hpa_pkg::*;
#(
   parameter int NUM_POOLS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic        req_dest_present,
   input  wire logic [15:0] req_dest_addr_low,
   input  wire logic [15:0] req_dest_port,
   input  wire logic [15:0] req_release_port,
   input  wire logic [4:0]  pool_count,
   input  wire logic        hold,
   output logic             push,
   output item_type         push_item
);

   localparam int HASH_STEPS = 5;   // 20 key bits, 4 bits a cycle

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_HASH = 2'b10
   } fstate_type;

   fstate_type  state_ff, state_in;
   item_type    item_ff, item_in;
   logic [19:0] key_ff, key_in;
   logic [5:0]  rem_ff, rem_in;
   logic [2:0]  step_ff, step_in;

   logic [7:0]  np;
   logic [16:0] key_sum;
   logic        accept;
   logic        needs_hash;
   logic [5:0]  rem_nxt;

   assign np         = active_pools(pool_count, 8'(NUM_POOLS));
   assign key_sum    = {1'b0, req_dest_addr_low} + {1'b0, req_dest_port};
   assign req_stall  = (state_ff != F_IDLE) || hold;
   assign accept     = req_valid && !req_stall;
   assign needs_hash = req_dest_present &&
                       ((req_type == REQ_FETCH) || (req_type == REQ_RELEASE));

   // four restoring remainder steps per cycle
   always_comb begin
      logic [5:0] r;
      r = rem_ff;
      for (int i = 0; i < 4; i++) begin
         r = {r[4:0], key_ff[19-i]};
         if (r >= 6'(np)) r = r - 6'(np);
      end
      rem_nxt = r;
   end

   // control
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      key_in    = key_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      push      = 1'b0;
      push_item = item_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               item_in.kind  = req_kind_type'(req_type);
               item_in.rport = req_release_port;
               item_in.pool  = '0;
               if (needs_hash) begin
                  key_in   = {3'b000, key_sum};
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = F_HASH;
               end else begin
                  push      = 1'b1;
                  push_item = item_in;
               end
            end
         end
         F_HASH: begin
            rem_in  = rem_nxt;
            key_in  = {key_ff[15:0], 4'b0000};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(HASH_STEPS - 1)) begin
               push           = 1'b1;
               push_item.pool = POOL_MAX_W'(rem_nxt);
               state_in       = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      item_ff <= item_in;
      key_ff  <= key_in;
      rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

>>> src/hpa_queue.sv
// ---------------------------------------------------------------------------
// hpa_queue
// short word queue between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none

module hpa_queue
   import hpa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  item_type      push_item,
   input  wire logic     pop,
   output item_type      pop_item,
   output logic          full,
   output logic          empty
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = slot_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule

`default_nettype wire

>>> src/hpa_back.sv
// ---------------------------------------------------------------------------
// hpa_back
// carries out init, fetch and release on the pool memories and counters
// ---------------------------------------------------------------------------
`default_nettype none
`include "hashed_port_pool_allocator_assert.svh"

module hpa_back
   import hpa_pkg::*;
#(
   parameter int NUM_POOLS = 16,
   parameter int PORT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   input  wire logic        q_empty,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             clearing,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_port_out,
   output logic [3:0]       rsp_pool_index,
   output logic [20:0]      rsp_used_total,
   output logic [20:0]      rsp_free_total,
   output logic [31:0]      rsp_miss_total
);

   localparam int POOL_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int MEM_W      = POOL_W + PORT_BITS;
   localparam int FIFO_DEPTH = 1 << MEM_W;
   localparam int SPAN       = 1 << PORT_BITS;
   localparam int TOT_W      = PORT_BITS + POOL_W + 1;
   localparam int MSUM_W     = 32 + POOL_W + 1;
   localparam logic [16:0] SPAN_M1 = 17'(SPAN - 1);

   typedef enum logic [7:0] {
      S_CLEAR    = 8'b00000001,
      S_IDLE     = 8'b00000010,
      S_READ     = 8'b00000100,
      S_FETCH    = 8'b00001000,
      S_RELEASE  = 8'b00010000,
      S_INIT_N   = 8'b00100000,
      S_INIT_SET = 8'b01000000,
      S_RESP     = 8'b10000000
   } bstate_type;

   // memories
   logic [PORT_BITS-1:0] fifo_mem [FIFO_DEPTH];
   logic [NUM_POOLS-1:0] used_mem [SPAN];

   bstate_type           state_ff, state_in;
   item_type             item_ff, item_in;
   logic [PORT_BITS-1:0] clr_ff, clr_in;
   logic                 clear_next_ff, clear_next_in;
   logic [PORT_BITS-1:0] free_cnt_ff [NUM_POOLS];
   logic [PORT_BITS-1:0] free_cnt_in [NUM_POOLS];
   logic [PORT_BITS-1:0] head_ff [NUM_POOLS];
   logic [PORT_BITS-1:0] head_in [NUM_POOLS];
   logic [PORT_BITS-1:0] tail_ff [NUM_POOLS];
   logic [PORT_BITS-1:0] tail_in [NUM_POOLS];
   logic [NUM_POOLS-1:0] wrap_ff, wrap_in;
   logic [NUM_POOLS-1:0] done_ff, done_in;
   logic [31:0]          miss_ff [NUM_POOLS];
   logic [31:0]          miss_in [NUM_POOLS];
   logic [MSUM_W-1:0]    miss_sum_ff, miss_sum_in;
   logic [TOT_W-1:0]     used_total_ff, used_total_in;
   logic [TOT_W-1:0]     free_total_ff, free_total_in;
   logic [16:0]          first_ff, first_in;
   logic [3:0]           shift_ff, shift_in;
   logic                 none_ff, none_in;
   logic [PORT_BITS-1:0] n_ff, n_in;
   logic                 orig_ff, orig_in;
   logic [PORT_BITS-1:0] calc_port_ff, calc_port_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [15:0]          rsp_port_ff, rsp_port_in;
   logic [3:0]           rsp_pool_ff, rsp_pool_in;
   logic [20:0]          rsp_used_ff, rsp_used_in;
   logic [20:0]          rsp_free_ff, rsp_free_in;
   logic [31:0]          rsp_miss_ff, rsp_miss_in;

   logic [PORT_BITS-1:0] fifo_rd_ff;
   logic [NUM_POOLS-1:0] used_rd_ff;
   logic                 fifo_we;
   logic [MEM_W-1:0]     fifo_waddr;
   logic [MEM_W-1:0]     fifo_raddr;
   logic [PORT_BITS-1:0] fifo_wdata;
   logic                 used_we;
   logic [PORT_BITS-1:0] used_waddr;
   logic [PORT_BITS-1:0] used_raddr;
   logic [NUM_POOLS-1:0] used_wmask;
   logic [NUM_POOLS-1:0] used_wdata;

   logic [POOL_W-1:0]    pool;
   logic [NUM_POOLS-1:0] pool_bit;
   logic [7:0]           np;
   logic [16:0]          lo17, hi17, hi_c, mask17, base17, f0;
   logic [PORT_BITS-1:0] head_sel, tail_sel, tail_nxt, fetch_port;

   assign pool       = item_ff.pool[POOL_W-1:0];
   assign pool_bit   = NUM_POOLS'(1) << pool;
   assign np         = active_pools(cfg.pool_count, 8'(NUM_POOLS));
   assign head_sel   = head_ff[pool];
   assign tail_sel   = tail_ff[pool];
   assign tail_nxt   = tail_sel + 1'b1;
   assign fetch_port = orig_ff ? calc_port_ff : fifo_rd_ff;
   assign fifo_raddr = {pool, head_sel};
   assign used_raddr = item_ff.rport[PORT_BITS-1:0];

   // init range terms
   assign lo17   = {1'b0, (cfg.port_low  == 16'd0) ? DEFAULT_LOW  : cfg.port_low};
   assign hi17   = {1'b0, (cfg.port_high == 16'd0) ? DEFAULT_HIGH : cfg.port_high};
   assign hi_c   = (hi17 > SPAN_M1) ? SPAN_M1 : hi17;
   assign mask17 = (17'd1 << cfg.index_shift) - 17'd1;
   assign base17 = 17'(cfg.port_base);
   assign f0     = (lo17 & ~mask17) | base17;

   // memory ports
   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
      fifo_rd_ff <= fifo_mem[fifo_raddr];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_POOLS; k++) begin
         if (used_we && used_wmask[k]) used_mem[used_waddr][k] <= used_wdata[k];
      end
      used_rd_ff <= used_mem[used_raddr];
   end

   // sequencer and counter updates
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      clr_in        = clr_ff;
      clear_next_in = clear_next_ff;
      free_cnt_in   = free_cnt_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      wrap_in       = wrap_ff;
      done_in       = done_ff;
      miss_in       = miss_ff;
      miss_sum_in   = miss_sum_ff;
      used_total_in = used_total_ff;
      free_total_in = free_total_ff;
      first_in      = first_ff;
      shift_in      = shift_ff;
      none_in       = none_ff;
      n_in          = n_ff;
      orig_in       = orig_ff;
      calc_port_in  = calc_port_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_pool_in   = rsp_pool_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_miss_in   = rsp_miss_ff;
      q_pop         = 1'b0;
      fifo_we       = 1'b0;
      fifo_waddr    = {pool, tail_sel};
      fifo_wdata    = item_ff.rport[PORT_BITS-1:0];
      used_we       = 1'b0;
      used_waddr    = used_raddr;
      used_wmask    = pool_bit;
      used_wdata    = '0;

      unique case (state_ff)
         // zero the used flags one row a cycle
         S_CLEAR: begin
            used_we    = 1'b1;
            used_waddr = clr_ff;
            used_wmask = '1;
            used_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = S_READ;
            end
         end
         // memory reads are in flight, classify the word
         S_READ: begin
            rsp_pool_in   = 4'(item_ff.pool);
            rsp_port_in   = '0;
            rsp_status_in = ST_OK;
            unique case (item_ff.kind)
               REQ_INIT: begin
                  if (lo17 > hi17) begin
                     rsp_status_in = ST_BAD_CONFIG;
                     state_in      = S_RESP;
                  end else begin
                     shift_in = cfg.index_shift;
                     if (cfg.index_shift == 4'd0) begin
                        first_in = lo17;
                        none_in  = 1'b0;
                     end else begin
                        first_in = (f0 < lo17) ? f0 + (17'd1 << cfg.index_shift) : f0;
                        none_in  = base17 > mask17;
                     end
                     state_in = S_INIT_N;
                  end
               end
               REQ_FETCH: begin
                  // slots below the init count hold the computed port until overwritten
                  orig_in = (head_sel < n_ff) && !done_ff[pool] &&
                            !(wrap_ff[pool] && (head_sel < tail_sel));
                  calc_port_in = PORT_BITS'(first_ff + (17'(head_sel) << shift_ff));
                  state_in     = S_FETCH;
               end
               REQ_RELEASE: state_in = S_RELEASE;
               default:     state_in = S_RESP;
            endcase
         end
         S_FETCH: begin
            if (free_cnt_ff[pool] == '0) begin
               rsp_status_in = ST_EMPTY;
               if (miss_ff[pool] != '1) begin
                  miss_in[pool] = miss_ff[pool] + 32'd1;
                  miss_sum_in   = miss_sum_ff + 1'b1;
               end
            end else begin
               rsp_port_in       = 16'(fetch_port);
               head_in[pool]     = head_sel + 1'b1;
               free_cnt_in[pool] = free_cnt_ff[pool] - 1'b1;
               used_total_in     = used_total_ff + 1'b1;
               free_total_in     = free_total_ff - 1'b1;
               used_we           = 1'b1;
               used_waddr        = fetch_port;
               used_wdata        = '1;
            end
            state_in = S_RESP;
         end
         S_RELEASE: begin
            if ((item_ff.rport == 16'd0) || ((item_ff.rport >> PORT_BITS) != 16'd0)) begin
               rsp_status_in = ST_BAD_PORT;
            end else if (!used_rd_ff[pool]) begin
               rsp_status_in = ST_NOT_USED;
            end else begin
               used_we           = 1'b1;
               used_wdata        = '0;
               fifo_we           = 1'b1;
               tail_in[pool]     = tail_nxt;
               if (tail_sel == '1) wrap_in[pool] = 1'b1;
               if ((wrap_ff[pool] || (tail_sel == '1)) && (tail_nxt == n_ff)) begin
                  done_in[pool] = 1'b1;
               end
               free_cnt_in[pool] = free_cnt_ff[pool] + 1'b1;
               used_total_in     = used_total_ff - 1'b1;
               free_total_in     = free_total_ff + 1'b1;
            end
            state_in = S_RESP;
         end
         // number of ports loaded into each pool
         S_INIT_N: begin
            if (!none_ff && (first_ff <= hi_c)) begin
               n_in = PORT_BITS'(((hi_c - first_ff) >> shift_ff) + 17'd1);
            end else begin
               n_in = '0;
            end
            state_in = S_INIT_SET;
         end
         S_INIT_SET: begin
            for (int k = 0; k < NUM_POOLS; k++) begin
               free_cnt_in[k] = (8'(k) < np) ? n_ff : '0;
               head_in[k]     = '0;
               tail_in[k]     = n_ff;
               miss_in[k]     = '0;
            end
            wrap_in       = '0;
            done_in       = '0;
            miss_sum_in   = '0;
            used_total_in = '0;
            free_total_in = TOT_W'(n_ff * np);
            clear_next_in = 1'b1;
            state_in      = S_RESP;
         end
         // load the result word with the updated totals
         S_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_used_in   = 21'(used_total_ff);
            rsp_free_in   = 21'(free_total_ff);
            rsp_miss_in   = (miss_sum_ff > MSUM_W'(32'hffffffff)) ? '1 : 32'(miss_sum_ff);
            clr_in        = '0;
            clear_next_in = 1'b0;
            state_in      = clear_next_ff ? S_CLEAR : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         clear_next_ff <= 1'b0;
         wrap_ff       <= '0;
         done_ff       <= '0;
         miss_sum_ff   <= '0;
         used_total_ff <= '0;
         free_total_ff <= '0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < NUM_POOLS; k++) begin
            free_cnt_ff[k] <= '0;
            head_ff[k]     <= '0;
            tail_ff[k]     <= '0;
            miss_ff[k]     <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         clear_next_ff <= clear_next_in;
         wrap_ff       <= wrap_in;
         done_ff       <= done_in;
         miss_sum_ff   <= miss_sum_in;
         used_total_ff <= used_total_in;
         free_total_ff <= free_total_in;
         n_ff          <= n_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_cnt_ff   <= free_cnt_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         miss_ff       <= miss_in;
      end
      item_ff       <= item_in;
      first_ff      <= first_in;
      shift_ff      <= shift_in;
      none_ff       <= none_in;
      orig_ff       <= orig_in;
      calc_port_ff  <= calc_port_in;
      rsp_status_ff <= rsp_status_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_pool_ff   <= rsp_pool_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_miss_ff   <= rsp_miss_in;
   end

   assign clearing       = (state_ff == S_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_port_out   = rsp_port_ff;
   assign rsp_pool_index = rsp_pool_ff;
   assign rsp_used_total = rsp_used_ff;
   assign rsp_free_total = rsp_free_ff;
   assign rsp_miss_total = rsp_miss_ff;

   // checks
   `HPA_ASSERT_NEXT(a_resp_loaded, state_ff == S_RESP, rsp_valid_ff, "result word not raised")
   `HPA_ASSERT_IMPLY(a_release_has_used, (state_ff == S_RELEASE) && fifo_we,
                     used_total_ff != '0, "release with no used port counted")
   `HPA_ASSERT_NEXT(a_clear_runs, (state_ff == S_CLEAR) && (clr_ff != '1),
                    state_ff == S_CLEAR, "clear sweep cut short")

endmodule

`default_nettype wire

>>> src/hashed_port_pool_allocator.sv
// ---------------------------------------------------------------------------
// hashed_port_pool_allocator
// source port allocator over hashed sub-pools with free-list fifos
// ---------------------------------------------------------------------------
// A request word is classified by the front, which picks the pool as
// (dest_addr_low + dest_port) mod active pool count in an iterative remainder
// unit (4 quotient bits a cycle); words without a destination skip it. A
// four-entry queue feeds the back, which steps through a fetch or release
// as pop, memory read, update and result, then returns to idle and takes
// the next word only once the last result has been taken. An init with a
// valid range goes through the port count and counter set states to the
// result, then the back sweeps the used-flag memory clear before the next
// word. After reset the same sweep runs and no word is accepted until it
// ends; register writes are taken at any time.
// ---------------------------------------------------------------------------
`default_nettype none

module hashed_port_pool_allocator
   import hpa_pkg::*;
#(
   parameter int NUM_POOLS = 16,
   parameter int PORT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic        req_dest_present,
   input  wire logic [15:0] req_dest_addr_low,
   input  wire logic [15:0] req_dest_port,
   input  wire logic [15:0] req_release_port,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_port_out,
   output logic [3:0]       rsp_pool_index,
   output logic [20:0]      rsp_used_total,
   output logic [20:0]      rsp_free_total,
   output logic [31:0]      rsp_miss_total,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type  cfg_ff, cfg_in;
   item_type push_item, pop_item;
   logic     push, pop, q_full, q_empty, clearing;
   logic     csr_write;
   logic [2:0] csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PORT_LOW:    cfg_in.port_low    = pwdata[15:0];
            CSR_PORT_HIGH:   cfg_in.port_high   = pwdata[15:0];
            CSR_INDEX_SHIFT: cfg_in.index_shift = pwdata[3:0];
            CSR_PORT_BASE:   cfg_in.port_base   = pwdata[14:0];
            CSR_POOL_COUNT:  cfg_in.pool_count  = pwdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         CSR_PORT_LOW:    prdata = {16'd0, cfg_ff.port_low};
         CSR_PORT_HIGH:   prdata = {16'd0, cfg_ff.port_high};
         CSR_INDEX_SHIFT: prdata = {28'd0, cfg_ff.index_shift};
         CSR_PORT_BASE:   prdata = {17'd0, cfg_ff.port_base};
         CSR_POOL_COUNT:  prdata = {27'd0, cfg_ff.pool_count};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_low    <= DEFAULT_LOW;
         cfg_ff.port_high   <= DEFAULT_HIGH;
         cfg_ff.index_shift <= 4'd0;
         cfg_ff.port_base   <= 15'd0;
         cfg_ff.pool_count  <= 5'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpa_front #(
      .NUM_POOLS (NUM_POOLS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_dest_present  (req_dest_present),
      .req_dest_addr_low (req_dest_addr_low),
      .req_dest_port     (req_dest_port),
      .req_release_port  (req_release_port),
      .pool_count        (cfg_ff.pool_count),
      .hold              (q_full || clearing),
      .push              (push),
      .push_item         (push_item)
   );

   hpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   hpa_back #(
      .NUM_POOLS (NUM_POOLS),
      .PORT_BITS (PORT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_port_out   (rsp_port_out),
      .rsp_pool_index (rsp_pool_index),
      .rsp_used_total (rsp_used_total),
      .rsp_free_total (rsp_free_total),
      .rsp_miss_total (rsp_miss_total)
   );

endmodule

`default_nettype wire
